### rtl/tdpt_pkg.sv
`timescale 1ns / 1ps
// tdpt_pkg: shared types for the trial division prime test.
// No dependencies.
package tdpt_pkg;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
    } div_stat_t;

endpackage

### rtl/tdpt_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the trial division prime test.
// No dependencies.
interface tdpt_value_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface tdpt_result_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

### rtl/tdpt_div.sv
`timescale 1ns / 1ps
// tdpt_div: restoring bit-serial divider, one quotient bit per cycle.
// Depends on tdpt_pkg for the control and status structs.
module tdpt_div #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tdpt_pkg::div_ctrl_t      ctrl,
    input  logic [VALUE_WIDTH-1:0]   dividend,
    input  logic [VALUE_WIDTH-1:0]   divisor,
    output tdpt_pkg::div_stat_t      stat,
    output logic [VALUE_WIDTH-1:0]   quotient,
    output logic [VALUE_WIDTH-1:0]   remainder
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [VALUE_WIDTH-1:0] shifted;
    logic                   fits;

    // remainder stays below the divisor, so the dropped top bit is zero while the divisor's top bit is clear
    assign shifted = {rem_reg[VALUE_WIDTH-2:0], quo_reg[VALUE_WIDTH-1]};
    assign fits    = (shifted >= dsr_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(VALUE_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (shifted - dsr_reg) : shifted;
            quo_next = {quo_reg[VALUE_WIDTH-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### rtl/trial_division_prime_test.sv
`timescale 1ns / 1ps
// trial_division_prime_test: top level, sequencer around one serial divider.
// Depends on tdpt_pkg, tdpt_ifs (channel interfaces) and tdpt_div.
//
// Usage:
//   value_ch  (sink)  : one signed VALUE_WIDTH-bit value per beat.
//   result_ch (source): one is_prime bit per value, in order.
//   Values below 2 (negatives included) give 0; 2 and 3 give 1; even values
//   give 0. Those answers are decided in ST_LOAD and offered in ST_DONE.
//   Odd values from 5 up are divided by 3, 5, 7, ... in a single restoring
//   divider, one divisor at a time. The loop ends when the divisor exceeds
//   the quotient (prime) or a remainder is zero; k divisors are tried, with
//   k <= (floor(sqrt(value)) + 1) / 2.
//   value_ch.ready is high only while the block is idle: one value at a time.
//   The result is held in an output register until result_ch.ready takes it;
//   a stalled receiver keeps the block from accepting the next value.
//   Reset (rst_n low, asynchronous) drops any value in flight and any result
//   not yet taken, and leaves the block idle and ready.
module trial_division_prime_test #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    tdpt_value_if.sink     value_ch,
    tdpt_result_if.source  result_ch
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic                   prime_reg, prime_next;

    tdpt_pkg::div_ctrl_t    div_ctrl;
    tdpt_pkg::div_stat_t    div_stat;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [VALUE_WIDTH-1:0] remainder;

    tdpt_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (n_reg),
        .divisor   (d_next),
        .stat      (div_stat),
        .quotient  (quotient),
        .remainder (remainder)
    );

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        prime_next     = prime_reg;
        div_ctrl.start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (value_ch.valid)
                begin
                    n_next     = value_ch.value;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (n_reg[VALUE_WIDTH-1] || (n_reg < VALUE_WIDTH'(2)))
                begin
                    prime_next = 1'b0;
                    state_next = ST_DONE;
                end
                else if (n_reg < VALUE_WIDTH'(4))
                begin
                    prime_next = 1'b1;
                    state_next = ST_DONE;
                end
                else if (!n_reg[0])
                begin
                    prime_next = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    d_next         = VALUE_WIDTH'(3);
                    div_ctrl.start = 1'b1;
                    state_next     = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    // bound first: divisor above n / divisor means no factor left
                    if (d_reg > quotient)
                    begin
                        prime_next = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (remainder == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        d_next         = d_reg + VALUE_WIDTH'(2);
                        div_ctrl.start = 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (result_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        prime_reg <= prime_next;
    end

    assign value_ch.ready     = (state_reg == ST_IDLE);
    assign result_ch.valid    = (state_reg == ST_DONE);
    assign result_ch.is_prime = prime_reg;

endmodule
